@@ rtl/i2f_pkg.sv @@
// ----------------------------------------------------------------------------
// Integer to single-precision conversion package
// Widths, exponent bias and the leading-one detector result type shared by
// the conversion pipeline and its leading-one detector.
// ----------------------------------------------------------------------------
`default_nettype none

package i2f_pkg;

    localparam int WORD_W   = 32;
    localparam int FRAC_W   = 23;
    localparam int EXP_W    = 8;
    localparam int POS_W    = $clog2(WORD_W);
    localparam int MANT_W   = FRAC_W + 1;
    localparam int EXP_BIAS = 127;

    typedef struct packed {
        logic             zero;
        logic [POS_W-1:0] pos;
    } lod_t;

endpackage : i2f_pkg

`default_nettype wire

@@ rtl/i2f_lod.sv @@
// ----------------------------------------------------------------------------
// Leading-one detector
// Gives the position of the most significant set bit of a word and flags a
// word that has no set bit at all.
// ----------------------------------------------------------------------------
`default_nettype none

module i2f_lod
    import i2f_pkg::*;
(
    input  wire logic [WORD_W-1:0] mag,
    output lod_t                   lod
);

    always_comb
    begin
        lod.pos  = '0;
        lod.zero = ~(|mag);
        for (int i = 0; i < WORD_W; i++)
        begin
            if (mag[i])
            begin
                lod.pos = POS_W'(i);
            end
        end
    end

endmodule : i2f_lod

`default_nettype wire

@@ rtl/int32_to_float32_convert_core.sv @@
// ----------------------------------------------------------------------------
// Signed 32-bit integer to IEEE 754 single-precision converter
// Converts each request of a two's complement integer into the bit pattern of
// the nearest single-precision value, rounding to nearest with ties to even.
//
// The input channel carries int_value under in_valid and in_stall; the output
// channel carries float_bits under out_valid and out_stall. A request is taken
// at a clock edge where valid is high and stall is low.
// The datapath is a four-register pipeline: magnitude, leading-one detect,
// normalise and round, then exponent assembly into the output register.
// A result passes the magnitude, leading-one detect and normalise and round
// registers before it shows on out_valid. Unless the output stalls, a new
// request may enter in every cycle, so the throughput is one request per cycle.
// Each stage loads whenever it is empty or the stage after it moves on, so
// a stall on the output only holds the stages that are full; empty stages
// behind it still fill. in_stall rises once every stage is full and the
// output is stalled. A stalled result is held unchanged on float_bits.
// Reset empties the pipeline at once; no request is in flight after it.
// ----------------------------------------------------------------------------
`default_nettype none

module int32_to_float32_convert_core
    import i2f_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [WORD_W-1:0] int_value,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [WORD_W-1:0]      float_bits
);

    logic              s1_valid_reg;
    logic              s1_sign_reg;
    logic [WORD_W-1:0] s1_mag_reg;

    logic              s2_valid_reg;
    logic              s2_sign_reg;
    logic              s2_zero_reg;
    logic [POS_W-1:0]  s2_pos_reg;
    logic [WORD_W-1:0] s2_mag_reg;

    logic              s3_valid_reg;
    logic              s3_sign_reg;
    logic              s3_zero_reg;
    logic [POS_W-1:0]  s3_pos_reg;
    logic [MANT_W-1:0] s3_mant_reg;
    logic              s3_round_reg;

    logic              out_valid_reg;
    logic [WORD_W-1:0] out_bits_reg;

    logic              adv1;
    logic              adv2;
    logic              adv3;
    logic              adv4;

    logic [WORD_W-1:0] s1_mag_next;
    lod_t              s2_lod;
    logic [WORD_W-1:0] s3_norm;
    logic [WORD_W-1:0] out_bits_next;
    logic [EXP_W-1:0]  exp_field;
    logic [MANT_W:0]   mant_rounded;

    assign adv4 = ~out_valid_reg | ~out_stall;
    assign adv3 = ~s3_valid_reg | adv4;
    assign adv2 = ~s2_valid_reg | adv3;
    assign adv1 = ~s1_valid_reg | adv2;

    assign in_stall   = ~adv1;
    assign out_valid  = out_valid_reg;
    assign float_bits = out_bits_reg;

    assign s1_mag_next = int_value[WORD_W-1] ? (WORD_W'(0) - int_value) : int_value;

    i2f_lod u_lod
    (
        .mag (s1_mag_reg),
        .lod (s2_lod)
    );

    assign s3_norm = s2_mag_reg << (POS_W'(WORD_W - 1) - s2_pos_reg);

    assign exp_field     = EXP_W'(s3_pos_reg) + EXP_W'(EXP_BIAS - 1);
    assign mant_rounded  = {1'b0, s3_mant_reg} + (MANT_W + 1)'(s3_round_reg);
    assign out_bits_next = s3_zero_reg ? '0 :
                           ({s3_sign_reg, exp_field, FRAC_W'(0)}
                            + WORD_W'(mant_rounded));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (adv2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (adv3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (adv4)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_sign_reg <= int_value[WORD_W-1];
            s1_mag_reg  <= s1_mag_next;
        end
        if (adv2)
        begin
            s2_sign_reg <= s1_sign_reg;
            s2_zero_reg <= s2_lod.zero;
            s2_pos_reg  <= s2_lod.pos;
            s2_mag_reg  <= s1_mag_reg;
        end
        if (adv3)
        begin
            s3_sign_reg  <= s2_sign_reg;
            s3_zero_reg  <= s2_zero_reg;
            s3_pos_reg   <= s2_pos_reg;
            s3_mant_reg  <= s3_norm[WORD_W-1 -: MANT_W];
            s3_round_reg <= s3_norm[WORD_W-MANT_W-1]
                            & ((|s3_norm[WORD_W-MANT_W-2:0]) | s3_norm[WORD_W-MANT_W]);
        end
        if (adv4)
        begin
            out_bits_reg <= out_bits_next;
        end
    end

endmodule : int32_to_float32_convert_core

`default_nettype wire

@@ rtl/i2f_checker.sv @@
// ----------------------------------------------------------------------------
// Integer to single-precision converter port checker
// Watches the ports of the converter for held results, pipeline flow and
// well-formed single-precision patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module i2f_checker
    import i2f_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_stall,
    input wire logic              out_valid,
    input wire logic              out_stall,
    input wire logic [WORD_W-1:0] float_bits
);

    localparam logic [EXP_W-1:0] EXP_MAX = EXP_W'(EXP_BIAS + WORD_W - 1);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(float_bits))
        else $error("Stalled result changed or vanished.");

    a_no_stall_through: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("Input stalled while output is free.");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !out_stall) ##1 !out_stall ##1 !out_stall
        ##1 !out_stall |=> out_valid)
        else $error("Request did not reach the output in four cycles.");

    a_zero_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (float_bits[WORD_W-2:FRAC_W] == '0) |-> float_bits == '0)
        else $error("Result has a zero exponent but is not positive zero.");

    a_exp_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> float_bits[WORD_W-2:FRAC_W] <= EXP_MAX)
        else $error("Result exponent beyond the range of a 32-bit integer.");

endmodule : i2f_checker

bind int32_to_float32_convert_core i2f_checker u_i2f_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .float_bits (float_bits)
);

`default_nettype wire

@@ verif/tb_int32_to_float32_convert_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the signed integer to single-precision converter
// Drives directed corner values (zero, the most negative integer, exact
// magnitudes, ties to even and carries into the exponent), then random
// requests with gaps on the input side and stalls on the output side. Each
// accepted request is converted by an independent predictor, and every
// result is compared with the oldest outstanding prediction.
// ----------------------------------------------------------------------------

class conversion_scoreboard;
    logic [i2f_pkg::WORD_W-1:0] single_q[$];
    int unsigned                mismatches = 0;

    function automatic logic [i2f_pkg::WORD_W-1:0] to_single(
        logic [i2f_pkg::WORD_W-1:0] raw);
        logic        sgn;
        logic [31:0] mag;
        logic [31:0] rem;
        logic [31:0] half;
        logic [31:0] mant;
        int          lead;
        int          sh;
        sgn = raw[31];
        mag = sgn ? (~raw + 32'd1) : raw;
        if (mag == 32'd0)
        begin
            return '0;
        end
        lead = 0;
        for (int i = 0; i < 32; i++)
        begin
            if (mag[i])
            begin
                lead = i;
            end
        end
        if (lead <= i2f_pkg::FRAC_W)
        begin
            mant = mag << (i2f_pkg::FRAC_W - lead);
        end
        else
        begin
            sh   = lead - i2f_pkg::FRAC_W;
            rem  = mag & ((32'd1 << sh) - 32'd1);
            half = 32'd1 << (sh - 1);
            mant = mag >> sh;
            if (rem > half || (rem == half && mant[0]))
            begin
                mant = mant + 32'd1;
            end
        end
        return {sgn, 31'b0} + (32'(lead + i2f_pkg::EXP_BIAS - 1) << i2f_pkg::FRAC_W)
            + mant;
    endfunction

    function void note_request(logic [i2f_pkg::WORD_W-1:0] operand);
        single_q.push_back(to_single(operand));
    endfunction

    function void check_result(logic [i2f_pkg::WORD_W-1:0] got);
        logic [i2f_pkg::WORD_W-1:0] want;
        if (single_q.size() == 0)
        begin
            $error("float_bits: unexpected result, expected none, actual %h", got);
            mismatches++;
        end
        else
        begin
            want = single_q.pop_front();
            if (got !== want)
            begin
                $error("float_bits: expected %h, actual %h", want, got);
                mismatches++;
            end
        end
    endfunction

    function int outstanding();
        return single_q.size();
    endfunction
endclass

module tb_int32_to_float32_convert_core;
    import i2f_pkg::*;

    localparam int RANDOM_REQUESTS = 650;
    localparam int IDLE_LIMIT      = 2000;
    localparam int DRAIN_CYCLES    = 16;

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              in_valid   = 1'b0;
    logic              in_stall;
    logic [WORD_W-1:0] int_value  = '0;
    logic              out_valid;
    logic              out_stall  = 1'b0;
    logic [WORD_W-1:0] float_bits;

    conversion_scoreboard sb = new;
    int unsigned          idle_cycles = 0;

    logic [WORD_W-1:0] directed[25] = '{
        32'h0000_0000, 32'h0000_0001, 32'hffff_ffff, 32'h7fff_ffff,
        32'h8000_0000, 32'h8000_0001, 32'h0100_0000, 32'h0100_0001,
        32'h0100_0003, 32'h0200_0001, 32'h0200_0003, 32'h00ff_ffff,
        32'hff00_0001, 32'h01ff_ffff, 32'hfeff_ffff, 32'h7fff_ffc0,
        32'h4000_0000, 32'hcf00_0000, 32'h007f_ffff, 32'hff7f_ffff,
        32'h0000_0037, 32'h0000_007f, 32'h5555_5555, 32'haaaa_aaaa,
        32'h7fff_ff80
    };

    int32_to_float32_convert_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .int_value  (int_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .float_bits (float_bits)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                sb.note_request(int_value);
            end
            if (out_valid && !out_stall)
            begin
                sb.check_result(float_bits);
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT)
                begin
                    $display("RESULT: ERROR");
                    $finish;
                end
            end
        end
    end

    function automatic int unsigned idle_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        else if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [WORD_W-1:0] random_operand();
        logic [63:0]       mask;
        logic [63:0]       low_mask;
        logic [63:0]       mag;
        logic [63:0]       half;
        logic [63:0]       pattern;
        int unsigned       width;
        int unsigned       sh;
        logic [WORD_W-1:0] operand;
        case ($urandom_range(0, 3))
            0:
            begin
                operand = $urandom;
            end
            1:
            begin
                width   = $urandom_range(1, 32);
                mask    = (64'd1 << width) - 64'd1;
                mag     = (64'($urandom) & mask) | (64'd1 << (width - 1));
                operand = mag[31:0];
                if ($urandom_range(0, 1))
                begin
                    operand = -operand;
                end
            end
            2:
            begin
                width    = $urandom_range(25, 32);
                sh       = width - 24;
                mask     = (64'd1 << width) - 64'd1;
                low_mask = (64'd1 << sh) - 64'd1;
                half     = 64'd1 << (sh - 1);
                case ($urandom_range(0, 3))
                    0: pattern = half;
                    1: pattern = half - 64'd1;
                    2: pattern = half + 64'd1;
                    default: pattern = low_mask;
                endcase
                mag = (64'($urandom) & mask) | (64'd1 << (width - 1));
                if ($urandom_range(0, 3) == 0)
                begin
                    mag = mask;
                end
                mag     = (mag & ~low_mask) | (pattern & low_mask);
                operand = mag[31:0];
                if ($urandom_range(0, 1))
                begin
                    operand = -operand;
                end
            end
            default:
            begin
                case ($urandom_range(0, 2))
                    0: operand = 32'h7fff_ffff - $urandom_range(0, 255);
                    1: operand = 32'h8000_0000 + $urandom_range(0, 255);
                    default: operand = $urandom_range(0, 511) - 256;
                endcase
            end
        endcase
        return operand;
    endfunction

    task automatic send_request(input logic [WORD_W-1:0] operand, input int unsigned gap);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid  <= 1'b0;
            int_value <= $urandom;
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        int_value <= operand;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
    endtask

    task automatic wait_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
        begin
            @(negedge clk);
        end
    endtask

    initial
    begin
        int unsigned hold;
        int unsigned run;
        wait (rst_n);
        forever
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                repeat ($urandom_range(20, 60))
                begin
                    @(negedge clk);
                    out_stall <= 1'b0;
                end
            end
            else
            begin
                hold = idle_length();
                run  = $urandom_range(1, 6);
                repeat (hold)
                begin
                    @(negedge clk);
                    out_stall <= 1'b1;
                end
                repeat (run)
                begin
                    @(negedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    initial
    begin
        int unsigned burst_left;
        int unsigned gap;

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
        begin
            send_request(directed[i], (i % 4 == 3) ? idle_length() : 0);
        end
        wait_until_drained();

        burst_left = 0;
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (burst_left > 0)
            begin
                gap = 0;
                burst_left--;
            end
            else if ($urandom_range(0, 19) == 0)
            begin
                gap        = 0;
                burst_left = $urandom_range(10, 40);
            end
            else
            begin
                gap = idle_length();
            end
            if ($urandom_range(0, 59) == 0)
            begin
                wait_until_drained();
            end
            send_request(random_operand(), gap);
        end

        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
